>>> design/assert_macros.svh
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication on every rising edge; held off during reset.
`define ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("assertion failed");

// Checks an implication on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clock, reset, prop)
`define ASSERT_ALWAYS(label, clock, prop)

`endif

`endif

>>> design/mbsp_pkg.sv
package mbsp_pkg;

  typedef logic [7:0] midi_byte_t;
  typedef logic [6:0] data_byte_t;

  localparam logic KIND_CHANNEL  = 1'b0;
  localparam logic KIND_GM_RESET = 1'b1;

  localparam midi_byte_t REALTIME_MIN = 8'hF8;
  localparam midi_byte_t SYSTEM_MIN   = 8'hF0;
  localparam midi_byte_t SYSEX_START  = 8'hF0;
  localparam midi_byte_t SYSEX_END    = 8'hF7;

  // Number of GM System On bytes that precede the closing F7.
  localparam logic [2:0] GM_ON_BODY_LEN = 3'd5;

  // Data bytes that follow a channel status byte; 0 for anything else.
  function automatic logic [1:0] data_len(input midi_byte_t status);
    logic [1:0] len;
    unique case (status[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd2;
      4'hC, 4'hD:                   len = 2'd1;
      default:                      len = 2'd0;
    endcase
    return len;
  endfunction

  // GM System On pattern F0 7E 7F 09 01 F7, indexed by match position.
  function automatic midi_byte_t gm_on_byte(input logic [2:0] idx);
    midi_byte_t b;
    unique case (idx)
      3'd0:    b = 8'hF0;
      3'd1:    b = 8'h7E;
      3'd2:    b = 8'h7F;
      3'd3:    b = 8'h09;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'hF7;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> design/midi_byte_stream_parser.sv
// Channel   Handshake          Payload
// in        in_valid/in_stall  midi_byte
// out       out_valid/out_stall event_kind, msg_status, msg_data0, msg_data1
// config    cfg_write          cfg_data (engine enable)
//
// One byte is taken per cycle unless the input stalls; its result, if any, appears
// in the output register on the next cycle. The parser state, the engine enable
// and the output register are the only storage; rst clears all but the payload.
// The input stalls only while the output register holds a result that is stalled.
`include "assert_macros.svh"

module midi_byte_stream_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mbsp_pkg::midi_byte_t midi_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 event_kind,
  output mbsp_pkg::midi_byte_t msg_status,
  output mbsp_pkg::data_byte_t msg_data0,
  output mbsp_pkg::data_byte_t msg_data1
);
  import mbsp_pkg::*;

  logic       engine_enable;
  midi_byte_t running_status;
  data_byte_t first_data;
  logic       data_count;
  logic [1:0] bytes_expected;
  logic [2:0] sysex_match_count;

  midi_byte_t running_status_next;
  data_byte_t first_data_next;
  logic       data_count_next;
  logic [1:0] bytes_expected_next;
  logic [2:0] sysex_match_count_next;

  logic       take;
  logic       res_valid;
  logic       res_kind;
  midi_byte_t res_status;
  data_byte_t res_data0;
  data_byte_t res_data1;

  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    running_status_next    = running_status;
    first_data_next        = first_data;
    data_count_next        = data_count;
    bytes_expected_next    = bytes_expected;
    sysex_match_count_next = sysex_match_count;
    res_valid  = 1'b0;
    res_kind   = KIND_CHANNEL;
    res_status = running_status;
    res_data0  = midi_byte[6:0];
    res_data1  = '0;

    if (midi_byte[7]) begin
      if (midi_byte >= REALTIME_MIN) begin
        // Realtime bytes pass through the parser untouched.
      end else if (midi_byte >= SYSTEM_MIN) begin
        running_status_next    = '0;
        data_count_next        = 1'b0;
        bytes_expected_next    = '0;
        sysex_match_count_next = (midi_byte == SYSEX_START) ? 3'd1 : 3'd0;
        if (midi_byte == SYSEX_END && sysex_match_count == GM_ON_BODY_LEN) begin
          res_valid  = 1'b1;
          res_kind   = KIND_GM_RESET;
          res_status = '0;
          res_data0  = '0;
        end
      end else begin
        sysex_match_count_next = '0;
        running_status_next    = midi_byte;
        data_count_next        = 1'b0;
        bytes_expected_next    = data_len(midi_byte);
      end
    end else if (bytes_expected == 2'd0) begin
      // Stray data bytes walk the GM System On match.
      if (sysex_match_count != 3'd0 && sysex_match_count < GM_ON_BODY_LEN &&
          midi_byte == gm_on_byte(sysex_match_count)) begin
        sysex_match_count_next = sysex_match_count + 3'd1;
      end else begin
        sysex_match_count_next = '0;
      end
    end else if (!data_count) begin
      if (bytes_expected == 2'd1) begin
        res_valid = 1'b1;
      end else begin
        first_data_next = midi_byte[6:0];
        data_count_next = 1'b1;
      end
    end else begin
      data_count_next = 1'b0;
      res_valid       = 1'b1;
      res_data0       = first_data;
      res_data1       = midi_byte[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_enable     <= 1'b0;
      running_status    <= '0;
      first_data        <= '0;
      data_count        <= 1'b0;
      bytes_expected    <= '0;
      sysex_match_count <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        engine_enable <= cfg_data;
      end
      if (take) begin
        running_status    <= running_status_next;
        first_data        <= first_data_next;
        data_count        <= data_count_next;
        bytes_expected    <= bytes_expected_next;
        sysex_match_count <= sysex_match_count_next;
        out_valid         <= res_valid & engine_enable;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result beat is loaded only when a byte is taken, so a stalled beat holds.
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      event_kind <= res_kind;
      msg_status <= res_status;
      msg_data0  <= res_data0;
      msg_data1  <= res_data1;
    end
  end

  `ASSERT_CLK(a_no_count_without_status, clk, rst, (bytes_expected == 2'd0) |-> !data_count)
  `ASSERT_CLK(a_match_in_range, clk, rst, sysex_match_count <= GM_ON_BODY_LEN)
  `ASSERT_CLK(a_status_matches_len, clk, rst,
    (bytes_expected != 2'd0) |-> (data_len(running_status) == bytes_expected))
  `ASSERT_CLK(a_reset_event_zero, clk, rst,
    (out_valid && event_kind == KIND_GM_RESET) |->
      (msg_status == 8'h00 && msg_data0 == 7'h00 && msg_data1 == 7'h00))
  `ASSERT_CLK(a_disabled_silent, clk, rst, (take && !engine_enable) |=> !out_valid)

endmodule

>>> tb/sv/midi_byte_stream_parser_tb.sv
`timescale 1ns / 100ps

module midi_byte_stream_parser_tb;
  import mbsp_pkg::*;

  localparam midi_byte_t NOTE_OFF      = 8'h80;
  localparam midi_byte_t NOTE_ON       = 8'h90;
  localparam midi_byte_t POLY_AT       = 8'hA0;
  localparam midi_byte_t CTRL_CHANGE   = 8'hB0;
  localparam midi_byte_t PROG_CHANGE   = 8'hC0;
  localparam midi_byte_t CHAN_PRESSURE = 8'hD0;
  localparam midi_byte_t PITCH_BEND    = 8'hE0;
  localparam midi_byte_t SONG_SELECT   = 8'hF3;
  localparam midi_byte_t TIMING_CLOCK  = 8'hF8;
  localparam midi_byte_t SYSTEM_RESET  = 8'hFF;
  localparam midi_byte_t DATA_MAX      = 8'h7F;

  // GM System On, first byte in the top octet.
  localparam logic [47:0] GM_ON_SEQ = 48'hF07E7F0901F7;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic       kind;
    midi_byte_t status;
    data_byte_t data0;
    data_byte_t data1;
  } midi_event_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data  = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  midi_byte_t midi_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       event_kind;
  midi_byte_t msg_status;
  data_byte_t msg_data0;
  data_byte_t msg_data1;

  midi_byte_t  pending_bytes[$];
  midi_event_t expected_events[$];

  int unsigned bytes_queued    = 0;
  int unsigned realtime_queued = 0;
  int unsigned bytes_accepted  = 0;
  int unsigned events_checked  = 0;
  int unsigned resets_checked  = 0;
  int unsigned error_count     = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  logic        in_beat_taken   = 1'b0;

  // Parser state as the block should hold it.
  logic       engine_on;
  midi_byte_t cur_status;
  data_byte_t first_seen;
  logic       have_first;
  logic [1:0] data_needed;
  logic [2:0] gm_matched;

  midi_byte_stream_parser dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .midi_byte  (midi_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .msg_status (msg_status),
    .msg_data0  (msg_data0),
    .msg_data1  (msg_data1)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [1:0] channel_data_bytes(input midi_byte_t status);
    return (status[7:4] == PROG_CHANGE[7:4] || status[7:4] == CHAN_PRESSURE[7:4]) ?
           2'd1 : 2'd2;
  endfunction

  function automatic midi_byte_t rand_data();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return DATA_MAX;
    return midi_byte_t'($urandom_range(0, DATA_MAX));
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic parse_midi_byte(input midi_byte_t b);
    midi_event_t ev;
    logic        fire;
    ev   = '0;
    fire = 1'b0;
    if (b >= REALTIME_MIN) begin
      // Realtime bytes pass straight through without touching the parser.
    end else if (b >= SYSTEM_MIN) begin
      if (b == SYSEX_END && gm_matched == GM_ON_BODY_LEN) begin
        ev.kind = KIND_GM_RESET;
        fire    = 1'b1;
      end
      cur_status  = '0;
      have_first  = 1'b0;
      data_needed = 2'd0;
      gm_matched  = (b == SYSEX_START) ? 3'd1 : 3'd0;
    end else if (b[7]) begin
      gm_matched  = 3'd0;
      cur_status  = b;
      have_first  = 1'b0;
      data_needed = channel_data_bytes(b);
    end else if (data_needed == 2'd0) begin
      if (gm_matched != 3'd0 && gm_matched < GM_ON_BODY_LEN &&
          b == GM_ON_SEQ[47 - 8 * gm_matched -: 8]) begin
        gm_matched++;
      end else begin
        gm_matched = 3'd0;
      end
    end else if (!have_first && data_needed == 2'd1) begin
      ev.kind   = KIND_CHANNEL;
      ev.status = cur_status;
      ev.data0  = b[6:0];
      fire      = 1'b1;
    end else if (!have_first) begin
      first_seen = b[6:0];
      have_first = 1'b1;
    end else begin
      have_first = 1'b0;
      ev.kind    = KIND_CHANNEL;
      ev.status  = cur_status;
      ev.data0   = first_seen;
      ev.data1   = b[6:0];
      fire       = 1'b1;
    end
    if (fire && engine_on) expected_events = {expected_events, ev};
  endtask

  task automatic check_event();
    midi_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event kind %0d status %h with none expected",
                                event_kind, msg_status));
    end else begin
      want = expected_events.pop_front();
      events_checked++;
      if (want.kind == KIND_GM_RESET) resets_checked++;
      if (event_kind !== want.kind)
        report_mismatch($sformatf("event_kind %0d, expected %0d", event_kind, want.kind));
      if (msg_status !== want.status)
        report_mismatch($sformatf("msg_status %h, expected %h", msg_status, want.status));
      if (msg_data0 !== want.data0)
        report_mismatch($sformatf("msg_data0 %h, expected %h", msg_data0, want.data0));
      if (msg_data1 !== want.data1)
        report_mismatch($sformatf("msg_data1 %h, expected %h", msg_data1, want.data1));
    end
  endtask

  // Monitor: checks the output beat, then runs the accepted input beat through the
  // predictor, so a stray result can never consume this edge's new expectation.
  always @(posedge clk) begin
    if (rst) begin
      engine_on     = 1'b0;
      cur_status    = '0;
      first_seen    = '0;
      have_first    = 1'b0;
      data_needed   = 2'd0;
      gm_matched    = 3'd0;
      in_beat_taken <= 1'b0;
    end else begin
      if (cfg_write) engine_on = cfg_data;
      if (out_valid && !out_stall) check_event();
      if (in_valid && !in_stall) begin
        bytes_accepted++;
        parse_midi_byte(midi_byte);
      end
      in_beat_taken <= in_valid && !in_stall;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("midi_byte_stream_parser verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        midi_byte <= pending_bytes.pop_front();
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic push_raw(input midi_byte_t b);
    pending_bytes = {pending_bytes, b};
    bytes_queued++;
  endtask

  // Now and then a realtime byte lands in front, as it may anywhere in a stream.
  task automatic queue_byte(input midi_byte_t b);
    if ($urandom_range(0, 99) < 4) begin
      push_raw(midi_byte_t'($urandom_range(REALTIME_MIN, SYSTEM_RESET)));
      realtime_queued++;
    end
    push_raw(b);
  endtask

  task automatic queue_channel_message(input midi_byte_t status, input int unsigned sets);
    queue_byte(status);
    repeat (sets) begin
      queue_byte(rand_data());
      if (channel_data_bytes(status) == 2'd2) queue_byte(rand_data());
    end
  endtask

  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int          i;
    start = bytes_queued - realtime_queued;
    while (bytes_queued - realtime_queued - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_channel_message(midi_byte_t'($urandom_range(NOTE_OFF, PITCH_BEND | 8'h0F)),
                              $urandom_range(1, 4));
        // Sometimes leave a message half done.
        if ($urandom_range(0, 9) == 0) queue_byte(rand_data());
      end else if (pick < 67) begin
        for (i = 0; i < 6; i++) queue_byte(GM_ON_SEQ[47 - 8 * i -: 8]);
      end else if (pick < 76) begin
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++) queue_byte(GM_ON_SEQ[47 - 8 * i -: 8]);
        case ($urandom_range(0, 3))
          0: queue_byte(rand_data());
          1: queue_channel_message(midi_byte_t'($urandom_range(NOTE_OFF, PITCH_BEND | 8'h0F)),
                                   1);
          2: queue_byte(SYSEX_END);
          default: queue_byte(SYSEX_START);
        endcase
      end else if (pick < 83) begin
        queue_byte(midi_byte_t'($urandom_range(SYSTEM_MIN, SYSEX_END)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) queue_byte(rand_data());
      end else begin
        queue_byte(midi_byte_t'($urandom_range(0, 8'hFF)));
      end
    end
  endtask

  task automatic write_engine_enable(input logic enable_value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= enable_value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Holds back new bytes until every beat is taken and every event is back.
  task automatic settle_parser();
    while (bytes_accepted != bytes_queued || expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    midi_byte_t opening[$];
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 12;
    stall_pct     = 60;
    write_engine_enable(1'b1);
    opening = '{NOTE_OFF | 8'h0F, 8'h00, DATA_MAX,
                NOTE_ON | 8'h0A, DATA_MAX, 8'h00,
                POLY_AT, 8'h10, TIMING_CLOCK, 8'h20,
                CTRL_CHANGE | 8'h05, 8'h07, SONG_SELECT, 8'h64,
                PROG_CHANGE | 8'h03, DATA_MAX,
                CHAN_PRESSURE, 8'h00, DATA_MAX,
                PITCH_BEND | 8'h0F, 8'h00, DATA_MAX,
                SYSEX_START, 8'h7E, 8'h7F, SYSTEM_RESET, 8'h09, 8'h01, SYSEX_END};
    foreach (opening[i]) push_raw(opening[i]);
    settle_parser();

    // Parsing continues with the engine off; nothing may come out.
    write_engine_enable(1'b0);
    queue_random_traffic(200);
    settle_parser();

    write_engine_enable(1'b1);
    send_idle_pct = 60;
    stall_pct     = 12;
    queue_random_traffic(150);
    settle_parser();
    queue_random_traffic(150);
    settle_parser();

    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random_traffic(300);
    settle_parser();

    $display("Summary: %0d bytes accepted, %0d channel messages and %0d GM resets checked.",
             bytes_accepted, events_checked - resets_checked, resets_checked);
    $display("Engine toggled off and on; idling on either side in turn, then none.");
    if (error_count == 0) begin
      $display("midi_byte_stream_parser verification clean");
    end else begin
      $display("midi_byte_stream_parser verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/mbsp_pkg.sv
design/midi_byte_stream_parser.sv
tb/sv/midi_byte_stream_parser_tb.sv
